### src/tdpc_pkg.sv
// tdpc_pkg: shared types, codes and constants for the ticket dispense poll controller
// no dependencies; imported by tdpc_ctrl, tdpc_datapath and the top level
`timescale 1ns / 1ps

package tdpc_pkg;

  // default number of ticket channels
  localparam int CHANNELS_DEF = 4;

  // largest chunk of tickets sent in one poll frame
  localparam int MAX_CHUNK = 15;

  // results emitted per input word at most
  localparam int MAX_RESULTS = 7;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int WD_W    = 9;
  localparam int STALL_W = 3;
  localparam int CNT_W   = 16;
  localparam int REM_W   = 8;

  // stall counter limits and marks
  localparam logic signed [STALL_W-1:0] STALL_MAX   = 3'sd3;
  localparam logic signed [STALL_W-1:0] STALL_BONUS = -3'sd1;

  // watchdog marks below zero
  localparam logic signed [WD_W-1:0] WD_EXPIRED = -9'sd1;
  localparam logic signed [WD_W-1:0] WD_TOLD    = -9'sd2;

  // reset value of the response timeout register
  localparam logic [7:0] TIMEOUT_RST = 8'd10;

  // input word kinds
  localparam logic [2:0] KIND_POLL   = 3'd0;
  localparam logic [2:0] KIND_RESP   = 3'd1;
  localparam logic [2:0] KIND_DISP   = 3'd2;
  localparam logic [2:0] KIND_ATTACH = 3'd3;
  localparam logic [2:0] KIND_PERR   = 3'd4;

  // result event codes
  localparam logic [3:0] EV_POLL     = 4'd0;
  localparam logic [3:0] EV_DONE     = 4'd1;
  localparam logic [3:0] EV_TIMEOUT  = 4'd2;
  localparam logic [3:0] EV_ABORT    = 4'd3;
  localparam logic [3:0] EV_BAD_CH   = 4'd4;
  localparam logic [3:0] EV_BUSY     = 4'd5;
  localparam logic [3:0] EV_CREDIT   = 4'd6;
  localparam logic [3:0] EV_IN_TMO   = 4'd7;
  localparam logic [3:0] EV_IN_ERR   = 4'd8;
  localparam logic [3:0] EV_REPLACED = 4'd9;

  // datapath step codes
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_CANCEL  = 4'd1;
  localparam logic [3:0] OP_FRAME   = 4'd2;
  localparam logic [3:0] OP_WDOG    = 4'd3;
  localparam logic [3:0] OP_FAIL_TO = 4'd4;
  localparam logic [3:0] OP_FAIL_AB = 4'd5;
  localparam logic [3:0] OP_CREDIT  = 4'd6;
  localparam logic [3:0] OP_INFORM  = 4'd7;
  localparam logic [3:0] OP_DISP    = 4'd8;
  localparam logic [3:0] OP_ATTACH  = 4'd9;
  localparam logic [3:0] OP_PERR    = 4'd10;
  localparam logic [3:0] OP_FLUSH   = 4'd11;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic [3:0] op;
    logic       idx_inc;
  } tdpc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic emit_ok;
    logic held;
    logic wd_neg;
    logic idx_last;
  } tdpc_stat_t;

  // one result word
  typedef struct packed {
    logic [3:0]       ev;
    logic             cv;
    logic [1:0]       ch;
    logic [CNT_W-1:0] count;
    logic             ack;
    logic [3:0]       code;
  } tdpc_res_t;

endpackage

### src/ticket_dispense_poll_controller_core.sv
// Flow: an input word runs through all its steps before the next is taken; a poll runs cancel,
// frame and watchdog steps and, when the watchdog has gone negative, a fail step for each channel.
// Throughput: one word at a time; results leave one per cycle through a staging register while
// out_ready keeps up, and a stalled output holds the sequencer.
// Reset (rst_n low, synchronous) clears all channel state, the watchdog and the listener,
// and loads response_timeout with 10. Configuration writes are taken in any cycle.
// Depends on tdpc_pkg, tdpc_ctrl and tdpc_datapath.
`timescale 1ns / 1ps

module ticket_dispense_poll_controller_core #(
  parameter int CHANNELS = tdpc_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic        in_channel_valid,
  input  logic [1:0]  in_channel_number,
  input  logic [15:0] in_ticket_amount,
  input  logic        in_credit_accepted,
  input  logic [3:0]  in_credit_code,
  input  logic [7:0]  in_reported_tickets,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_res,
  output logic        out_channel_valid,
  output logic [1:0]  out_channel,
  output logic [15:0] out_count,
  output logic        out_ack_bit,
  output logic [3:0]  out_credit_code,
  output logic        out_last
);
  import tdpc_pkg::*;

  tdpc_cmd_t  cmd;
  tdpc_stat_t stat;
  tdpc_res_t  res;

  assign cfg_ready = 1'b1;

  // sequencer
  tdpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  // channel state and result path
  tdpc_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_valid           (cfg_valid),
    .cfg_data            (cfg_data),
    .in_channel_valid    (in_channel_valid),
    .in_channel_number   (in_channel_number),
    .in_ticket_amount    (in_ticket_amount),
    .in_credit_accepted  (in_credit_accepted),
    .in_credit_code      (in_credit_code),
    .in_reported_tickets (in_reported_tickets),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_res             (res),
    .out_last            (out_last)
  );

  // unpack the result word
  assign out_event_res     = res.ev;
  assign out_channel_valid = res.cv;
  assign out_channel       = res.ch;
  assign out_count         = res.count;
  assign out_ack_bit       = res.ack;
  assign out_credit_code   = res.code;

  // no staged result is left behind when a new word can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.held)
    else $error("staged result pending while idle");

  // ready is low in the cycle after a word is accepted
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready did not drop after accepting a word");

  // a result naming a channel names an existing one
  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel_valid |-> (int'(out_channel) < CHANNELS))
    else $error("result names a channel out of range");

endmodule

### src/tdpc_ctrl.sv
// tdpc_ctrl: sequencer that walks each input word through its datapath steps
// depends on tdpc_pkg for step codes and the command and status structs
`timescale 1ns / 1ps

module tdpc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  tdpc_pkg::tdpc_stat_t stat,
  output tdpc_pkg::tdpc_cmd_t  cmd
);
  import tdpc_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CANCEL  = 4'd1;
  localparam logic [3:0] ST_FRAME   = 4'd2;
  localparam logic [3:0] ST_WDOG    = 4'd3;
  localparam logic [3:0] ST_FAIL_TO = 4'd4;
  localparam logic [3:0] ST_FAIL_AB = 4'd5;
  localparam logic [3:0] ST_CREDIT  = 4'd6;
  localparam logic [3:0] ST_INFORM  = 4'd7;
  localparam logic [3:0] ST_DISP    = 4'd8;
  localparam logic [3:0] ST_ATTACH  = 4'd9;
  localparam logic [3:0] ST_PERR    = 4'd10;
  localparam logic [3:0] ST_FLUSH   = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // next state and step commands
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.idx_inc = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_kind)
            KIND_POLL:   state_nxt = ST_CANCEL;
            KIND_RESP:   state_nxt = ST_CREDIT;
            KIND_DISP:   state_nxt = ST_DISP;
            KIND_ATTACH: state_nxt = ST_ATTACH;
            KIND_PERR:   state_nxt = ST_PERR;
            default:     state_nxt = ST_FLUSH;
          endcase
        end
      end
      ST_CANCEL: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_CANCEL;
          state_nxt = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_FRAME;
          state_nxt = ST_WDOG;
        end
      end
      ST_WDOG: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_WDOG;
          state_nxt = stat.wd_neg ? ST_FAIL_TO : ST_FLUSH;
        end
      end
      ST_FAIL_TO: begin
        if (stat.emit_ok) begin
          cmd.op      = OP_FAIL_TO;
          cmd.idx_inc = 1'b1;
          if (stat.idx_last) state_nxt = ST_FLUSH;
        end
      end
      ST_FAIL_AB: begin
        if (stat.emit_ok) begin
          cmd.op      = OP_FAIL_AB;
          cmd.idx_inc = 1'b1;
          if (stat.idx_last) state_nxt = ST_FLUSH;
        end
      end
      ST_CREDIT: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_CREDIT;
          state_nxt = ST_INFORM;
        end
      end
      ST_INFORM: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_INFORM;
          state_nxt = ST_FLUSH;
        end
      end
      ST_DISP: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_DISP;
          state_nxt = ST_FLUSH;
        end
      end
      ST_ATTACH: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_ATTACH;
          state_nxt = ST_FLUSH;
        end
      end
      ST_PERR: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_PERR;
          state_nxt = ST_FAIL_AB;
        end
      end
      ST_FLUSH: begin
        if (stat.emit_ok) begin
          cmd.op    = OP_FLUSH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/tdpc_datapath.sv
// tdpc_datapath: channel state, watchdog, word latch, result staging and output register
// depends on tdpc_pkg; steps are chosen by tdpc_ctrl through tdpc_cmd_t
`timescale 1ns / 1ps

module tdpc_datapath #(
  parameter int CHANNELS = tdpc_pkg::CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tdpc_pkg::tdpc_cmd_t        cmd,
  output tdpc_pkg::tdpc_stat_t       stat,
  input  logic                       cfg_valid,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_channel_valid,
  input  logic [1:0]                 in_channel_number,
  input  logic [tdpc_pkg::CNT_W-1:0] in_ticket_amount,
  input  logic                       in_credit_accepted,
  input  logic [3:0]                 in_credit_code,
  input  logic [tdpc_pkg::REM_W-1:0] in_reported_tickets,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tdpc_pkg::tdpc_res_t        out_res,
  output logic                       out_last
);
  import tdpc_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // per-channel state
  logic [CNT_W-1:0]          pend_r  [CHANNELS];
  logic [CNT_W-1:0]          pend_nxt[CHANNELS];
  logic                      act_r   [CHANNELS];
  logic                      act_nxt [CHANNELS];
  logic [REM_W-1:0]          lrem_r  [CHANNELS];
  logic [REM_W-1:0]          lrem_nxt[CHANNELS];
  logic signed [STALL_W-1:0] stall_r  [CHANNELS];
  logic signed [STALL_W-1:0] stall_nxt[CHANNELS];

  // global state
  logic signed [WD_W-1:0] wd_r, wd_nxt;
  logic                   ack_r, ack_nxt;
  logic                   lsn_r, lsn_nxt;
  logic [7:0]             tmo_r;

  // latched input word
  logic             cv_r;
  logic [1:0]       ch_r;
  logic [CNT_W-1:0] amt_r;
  logic             crd_r;
  logic [3:0]       code_r;
  logic [REM_W-1:0] rep_r;

  // poll bookkeeping and sweep index
  logic            cxl_r, cxl_nxt;
  logic [CH_W-1:0] sel_r, sel_nxt;
  logic [CH_W-1:0] idx_r;

  // result staging and output
  logic              hold_v_r, hold_v_nxt;
  tdpc_res_t         hold_r, hold_nxt;
  logic [RCNT_W-1:0] rcnt_r, rcnt_nxt;
  logic              out_v_r, out_v_nxt;
  tdpc_res_t         out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  logic            known;
  logic [CH_W-1:0] ch_idx;
  logic            emit;
  logic            emit_go;
  tdpc_res_t       res;

  assign known  = cv_r && (int'(ch_r) < CHANNELS);
  assign ch_idx = CH_W'(ch_r);

  // status toward the controller
  assign stat.emit_ok  = !hold_v_r || !out_v_r || out_ready;
  assign stat.held     = hold_v_r;
  assign stat.wd_neg   = wd_r[WD_W-1];
  assign stat.idx_last = (idx_r == CH_W'(CHANNELS - 1));

  // step logic: channel state updates and the result of this step
  always_comb begin
    logic             c_found;
    logic [CH_W-1:0]  c_sel;
    logic             s_found;
    logic [CH_W-1:0]  s_sel;
    logic [CNT_W-1:0] chunk;
    logic [REM_W-1:0] used;
    logic [CNT_W-1:0] pend_left;
    c_found   = 1'b0;
    c_sel     = '0;
    s_found   = 1'b0;
    s_sel     = '0;
    chunk     = '0;
    used      = '0;
    pend_left = '0;
    pend_nxt  = pend_r;
    act_nxt   = act_r;
    lrem_nxt  = lrem_r;
    stall_nxt = stall_r;
    wd_nxt    = wd_r;
    ack_nxt   = ack_r;
    lsn_nxt   = lsn_r;
    cxl_nxt   = cxl_r;
    sel_nxt   = sel_r;
    emit      = 1'b0;
    res       = '0;

    // lowest active channel that stalled out
    for (int i = 0; i < CHANNELS; i++) begin
      if (!c_found && act_r[i] && (stall_r[i] == STALL_MAX)) begin
        c_found = 1'b1;
        c_sel   = CH_W'(i);
      end
    end
    // lowest idle channel with tickets pending
    for (int i = 0; i < CHANNELS; i++) begin
      if (!s_found && !act_r[i] && (pend_r[i] != '0)) begin
        s_found = 1'b1;
        s_sel   = CH_W'(i);
      end
    end

    unique case (cmd.op)
      OP_CANCEL: begin
        cxl_nxt = c_found;
        sel_nxt = c_sel;
        if (c_found) begin
          emit             = 1'b1;
          res.ev           = EV_TIMEOUT;
          res.cv           = 1'b1;
          res.ch           = 2'(c_sel);
          res.count        = pend_r[c_sel];
          act_nxt[c_sel]   = 1'b0;
          pend_nxt[c_sel]  = '0;
          stall_nxt[c_sel] = '0;
        end
      end
      OP_FRAME: begin
        ack_nxt = ~ack_r;
        emit    = 1'b1;
        res.ev  = EV_POLL;
        res.ack = ack_r;
        if (cxl_r) begin
          res.cv = 1'b1;
          res.ch = 2'(sel_r);
        end else if (s_found) begin
          chunk = (pend_r[s_sel] < CNT_W'(MAX_CHUNK)) ? pend_r[s_sel] : CNT_W'(MAX_CHUNK);
          lrem_nxt[s_sel] = REM_W'(chunk);
          act_nxt[s_sel]  = 1'b1;
          res.cv          = 1'b1;
          res.ch          = 2'(s_sel);
          res.count       = chunk;
        end
      end
      OP_WDOG: begin
        if (!wd_r[WD_W-1]) begin
          wd_nxt = wd_r - 9'sd1;
        end else if ((wd_r == WD_EXPIRED) && lsn_r) begin
          wd_nxt = WD_TOLD;
          emit   = 1'b1;
          res.ev = EV_IN_TMO;
        end
      end
      OP_FAIL_TO, OP_FAIL_AB: begin
        if (act_r[idx_r]) begin
          emit             = 1'b1;
          res.ev           = (cmd.op == OP_FAIL_TO) ? EV_TIMEOUT : EV_ABORT;
          res.cv           = 1'b1;
          res.ch           = 2'(idx_r);
          res.count        = pend_r[idx_r];
          act_nxt[idx_r]   = 1'b0;
          pend_nxt[idx_r]  = '0;
          stall_nxt[idx_r] = '0;
        end
      end
      OP_CREDIT: begin
        if (crd_r && lsn_r) begin
          emit     = 1'b1;
          res.ev   = EV_CREDIT;
          res.code = code_r;
        end
      end
      OP_INFORM: begin
        wd_nxt = signed'({1'b0, tmo_r});
        if (known && act_r[ch_idx]) begin
          if (lrem_r[ch_idx] > rep_r) begin
            used      = lrem_r[ch_idx] - rep_r;
            pend_left = (pend_r[ch_idx] > CNT_W'(used)) ? pend_r[ch_idx] - CNT_W'(used) : '0;
            stall_nxt[ch_idx] = '0;
            pend_nxt[ch_idx]  = pend_left;
            if (pend_left == '0) begin
              emit            = 1'b1;
              res.ev          = EV_DONE;
              res.cv          = 1'b1;
              res.ch          = ch_r;
              act_nxt[ch_idx] = 1'b0;
            end else if (rep_r == '0) begin
              act_nxt[ch_idx]   = 1'b0;
              stall_nxt[ch_idx] = STALL_BONUS;
            end
          end else if (stall_r[ch_idx] < STALL_MAX) begin
            stall_nxt[ch_idx] = stall_r[ch_idx] + 3'sd1;
          end
          lrem_nxt[ch_idx] = rep_r;
        end
      end
      OP_DISP: begin
        if (amt_r == '0) begin
          emit   = 1'b1;
          res.ev = EV_DONE;
          res.cv = known;
          res.ch = ch_r;
        end else if (!known) begin
          emit      = 1'b1;
          res.ev    = EV_BAD_CH;
          res.count = amt_r;
        end else if (act_r[ch_idx]) begin
          emit      = 1'b1;
          res.ev    = EV_BUSY;
          res.cv    = 1'b1;
          res.ch    = ch_r;
          res.count = amt_r;
        end else begin
          pend_nxt[ch_idx] = amt_r;
        end
      end
      OP_ATTACH: begin
        if (lsn_r) begin
          emit   = 1'b1;
          res.ev = EV_REPLACED;
        end
        lsn_nxt = 1'b1;
        if (wd_r[WD_W-1]) wd_nxt = WD_EXPIRED;
      end
      OP_PERR: begin
        if (lsn_r) begin
          emit   = 1'b1;
          res.ev = EV_IN_ERR;
        end
      end
      default: begin
      end
    endcase
  end

  // staging: a new result pushes the held one out, flush marks the held one last
  assign emit_go = emit && (rcnt_r != RCNT_W'(MAX_RESULTS));

  always_comb begin
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    rcnt_nxt     = rcnt_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    if (cmd.load) rcnt_nxt = '0;
    if (emit_go) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = hold_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt = 1'b1;
      hold_nxt   = res;
      rcnt_nxt   = rcnt_r + 1'b1;
    end
    if ((cmd.op == OP_FLUSH) && hold_v_r) begin
      out_v_nxt    = 1'b1;
      out_nxt      = hold_r;
      out_last_nxt = 1'b1;
      hold_v_nxt   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pend_r[i]  <= '0;
        act_r[i]   <= 1'b0;
        lrem_r[i]  <= '0;
        stall_r[i] <= '0;
      end
      wd_r     <= '0;
      ack_r    <= 1'b0;
      lsn_r    <= 1'b0;
      tmo_r    <= TIMEOUT_RST;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      rcnt_r   <= '0;
      idx_r    <= '0;
      cxl_r    <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      act_r    <= act_nxt;
      lrem_r   <= lrem_nxt;
      stall_r  <= stall_nxt;
      wd_r     <= wd_nxt;
      ack_r    <= ack_nxt;
      lsn_r    <= lsn_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      rcnt_r   <= rcnt_nxt;
      cxl_r    <= cxl_nxt;
      if (cfg_valid) tmo_r <= cfg_data;
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (cmd.load) begin
      cv_r   <= in_channel_valid;
      ch_r   <= in_channel_number;
      amt_r  <= in_ticket_amount;
      crd_r  <= in_credit_accepted;
      code_r <= in_credit_code;
      rep_r  <= in_reported_tickets;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

endmodule

### sim/tb.sv
// tb: self-checking bench for ticket_dispense_poll_controller_core, link model inline
// depends on tdpc_pkg and the core; directed table first, then paced random phases
`timescale 1ns / 1ps

module tb;
  import tdpc_pkg::*;

  // spare input kinds that the core must ignore
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // receiver stall modes
  localparam logic [1:0] RDY_OPEN    = 2'd0;
  localparam logic [1:0] RDY_PATTERN = 2'd1;
  localparam logic [1:0] RDY_RANDOM  = 2'd2;

  localparam int NCH          = CHANNELS_DEF;
  localparam int PHASE_WORDS  = 72;
  localparam int SETTLE_CYC   = 12;

  typedef struct packed {
    logic [2:0]       kind;
    logic             chv;
    logic [1:0]       chn;
    logic [CNT_W-1:0] amount;
    logic             credit;
    logic [3:0]       code;
    logic [REM_W-1:0] rep;
  } link_word_t;

  typedef struct packed {
    logic [3:0]       ev;
    logic             cv;
    logic [1:0]       ch;
    logic [CNT_W-1:0] count;
    logic             ack;
    logic [3:0]       code;
    logic             last;
  } link_event_t;

  typedef struct packed {
    link_word_t  w;
    logic        typed;
    link_event_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_kind = '0;
  logic in_channel_valid = 1'b0;
  logic [1:0] in_channel_number = '0;
  logic [15:0] in_ticket_amount = '0;
  logic in_credit_accepted = 1'b0;
  logic [3:0] in_credit_code = '0;
  logic [7:0] in_reported_tickets = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [3:0] out_event_res;
  logic out_channel_valid;
  logic [1:0] out_channel;
  logic [15:0] out_count;
  logic out_ack_bit;
  logic [3:0] out_credit_code;
  logic out_last;

  ticket_dispense_poll_controller_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_channel_valid    (in_channel_valid),
    .in_channel_number   (in_channel_number),
    .in_ticket_amount    (in_ticket_amount),
    .in_credit_accepted  (in_credit_accepted),
    .in_credit_code      (in_credit_code),
    .in_reported_tickets (in_reported_tickets),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_channel_valid   (out_channel_valid),
    .out_channel         (out_channel),
    .out_count           (out_count),
    .out_ack_bit         (out_ack_bit),
    .out_credit_code     (out_credit_code),
    .out_last            (out_last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // link model state
  logic [CNT_W-1:0]          chan_pending [NCH];
  logic                      chan_active [NCH];
  logic [REM_W-1:0]          chan_remainder [NCH];
  logic signed [STALL_W-1:0] chan_stall [NCH];
  logic signed [WD_W-1:0]    watchdog;
  logic                      ack_toggle;
  logic                      listener_on;
  logic [7:0]                timeout_reg;

  link_event_t item_events[$];
  link_event_t due_events[$];
  stim_row_t   row_q[$];

  int fails = 0;
  int words_taken = 0;
  int results_seen = 0;
  logic [15:0] events_hit = '0;

  function automatic void note_event(logic [3:0] ev, logic cv, logic [1:0] ch,
                                     logic [CNT_W-1:0] cnt, logic ack, logic [3:0] code);
    link_event_t e;
    e.ev = ev;
    e.cv = cv;
    e.ch = ch;
    e.count = cnt;
    e.ack = ack;
    e.code = code;
    e.last = 1'b0;
    item_events.push_back(e);
  endfunction

  function automatic void idle_channel(int i);
    chan_active[i] = 1'b0;
    chan_pending[i] = '0;
    chan_stall[i] = '0;
  endfunction

  // every active channel fails with the given event
  function automatic void fail_active(logic [3:0] ev);
    for (int i = 0; i < NCH; i++) begin
      if (chan_active[i]) begin
        note_event(ev, 1'b1, i[1:0], chan_pending[i], 1'b0, 4'd0);
        idle_channel(i);
      end
    end
  endfunction

  // poll tick: cancel a stalled channel or start an idle one, then the watchdog
  function automatic void run_poll();
    int sel;
    logic [CNT_W-1:0] chunk;
    logic ack_now;
    sel = -1;
    chunk = '0;
    ack_now = ack_toggle;
    ack_toggle = ~ack_toggle;
    for (int i = 0; i < NCH; i++) begin
      if (sel < 0 && chan_active[i] && chan_stall[i] == STALL_MAX) begin
        note_event(EV_TIMEOUT, 1'b1, i[1:0], chan_pending[i], 1'b0, 4'd0);
        idle_channel(i);
        sel = i;
      end
    end
    if (sel < 0) begin
      for (int i = 0; i < NCH; i++) begin
        if (sel < 0 && !chan_active[i] && chan_pending[i] != 0) begin
          chunk = (chan_pending[i] < MAX_CHUNK) ? chan_pending[i] : CNT_W'(MAX_CHUNK);
          chan_remainder[i] = chunk[REM_W-1:0];
          chan_active[i] = 1'b1;
          sel = i;
        end
      end
    end
    if (sel >= 0) note_event(EV_POLL, 1'b1, sel[1:0], chunk, ack_now, 4'd0);
    else note_event(EV_POLL, 1'b0, 2'd0, '0, ack_now, 4'd0);
    if (watchdog >= 0) begin
      watchdog = watchdog - 9'sd1;
    end else begin
      if (watchdog == WD_EXPIRED && listener_on) begin
        watchdog = WD_TOLD;
        note_event(EV_IN_TMO, 1'b0, 2'd0, '0, 1'b0, 4'd0);
      end
      fail_active(EV_TIMEOUT);
    end
  endfunction

  // response on an active channel: track the drop in the remainder
  function automatic void run_inform(int i, logic [REM_W-1:0] rep);
    logic [CNT_W-1:0] used;
    if (chan_remainder[i] > rep) begin
      used = CNT_W'(chan_remainder[i] - rep);
      chan_stall[i] = '0;
      chan_pending[i] = (chan_pending[i] > used) ? chan_pending[i] - used : '0;
      if (chan_pending[i] == 0) begin
        note_event(EV_DONE, 1'b1, i[1:0], '0, 1'b0, 4'd0);
        idle_channel(i);
      end else if (rep == 0) begin
        chan_active[i] = 1'b0;
        chan_stall[i] = STALL_BONUS;
      end
    end else if (chan_stall[i] < STALL_MAX) begin
      chan_stall[i] = chan_stall[i] + 3'sd1;
    end
    chan_remainder[i] = rep;
  endfunction

  // events one accepted word gives rise to, last flag on the final one
  function automatic void predict_link_events(link_word_t w);
    item_events.delete();
    case (w.kind)
      KIND_POLL: run_poll();
      KIND_RESP: begin
        if (w.credit && listener_on) note_event(EV_CREDIT, 1'b0, 2'd0, '0, 1'b0, w.code);
        if (w.chv && chan_active[w.chn]) run_inform(w.chn, w.rep);
        watchdog = {1'b0, timeout_reg};
      end
      KIND_DISP: begin
        if (w.amount == 0) note_event(EV_DONE, w.chv, w.chn, '0, 1'b0, 4'd0);
        else if (!w.chv) note_event(EV_BAD_CH, 1'b0, 2'd0, w.amount, 1'b0, 4'd0);
        else if (chan_active[w.chn]) note_event(EV_BUSY, 1'b1, w.chn, w.amount, 1'b0, 4'd0);
        else chan_pending[w.chn] = w.amount;
      end
      KIND_ATTACH: begin
        if (listener_on) note_event(EV_REPLACED, 1'b0, 2'd0, '0, 1'b0, 4'd0);
        listener_on = 1'b1;
        if (watchdog < 0) watchdog = WD_EXPIRED;
      end
      KIND_PERR: begin
        if (listener_on) note_event(EV_IN_ERR, 1'b0, 2'd0, '0, 1'b0, 4'd0);
        fail_active(EV_ABORT);
      end
      default: ;
    endcase
    if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
  endfunction

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $error("%s expected %0d got %0d", name, want, seen);
      fails++;
    end
  endfunction

  // result check first, then config and word acceptance at the same edge
  always @(posedge clk) begin : link_monitor
    link_event_t got;
    link_event_t exp_ev;
    stim_row_t row;
    link_word_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_event_res, out_channel_valid, out_channel, out_count, out_ack_bit,
               out_credit_code, out_last};
        results_seen++;
        events_hit[out_event_res] = 1'b1;
        if (due_events.size() == 0) begin
          $error("unexpected result word, event %0d", out_event_res);
          fails++;
        end else begin
          exp_ev = due_events.pop_front();
          field_check("out_event_res", exp_ev.ev, got.ev);
          field_check("out_channel_valid", exp_ev.cv, got.cv);
          field_check("out_channel", exp_ev.ch, got.ch);
          field_check("out_count", exp_ev.count, got.count);
          field_check("out_ack_bit", exp_ev.ack, got.ack);
          field_check("out_credit_code", exp_ev.code, got.code);
          field_check("out_last", exp_ev.last, got.last);
        end
      end
      if (cfg_valid && cfg_ready) timeout_reg = cfg_data;
      if (in_valid && in_ready) begin
        w = {in_kind, in_channel_valid, in_channel_number, in_ticket_amount,
             in_credit_accepted, in_credit_code, in_reported_tickets};
        words_taken++;
        predict_link_events(w);
        if (row_q.size() != 0) begin
          row = row_q.pop_front();
          if (row.typed) begin
            item_events.delete();
            item_events.push_back(row.want);
          end
        end
        foreach (item_events[i]) due_events.push_back(item_events[i]);
      end
    end
  end

  // receiver stalls: open, rotating pattern or random, in spans
  logic [1:0] rdy_mode = RDY_OPEN;
  logic [6:0] rdy_span = '0;
  logic [7:0] rdy_pat = 8'h01;

  always @(posedge clk) begin
    if (rdy_span == 0) begin
      rdy_mode <= 2'($urandom_range(0, 2));
      rdy_span <= 7'($urandom_range(8, 64));
      rdy_pat <= 8'($urandom) | 8'h01;
    end else begin
      rdy_span <= rdy_span - 7'd1;
      rdy_pat <= {rdy_pat[6:0], rdy_pat[7]};
    end
    case (rdy_mode)
      RDY_OPEN:    out_ready <= 1'b1;
      RDY_PATTERN: out_ready <= rdy_pat[0];
      default:     out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic stim_row_t mk(logic [2:0] k, logic chv, logic [1:0] chn,
                                   logic [15:0] amt, logic cr, logic [3:0] code,
                                   logic [7:0] rep);
    stim_row_t r;
    r.w = {k, chv, chn, amt, cr, code, rep};
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t mk_want(stim_row_t r, logic [3:0] ev, logic cv,
                                        logic [1:0] ch, logic [15:0] cnt, logic ack);
    r.typed = 1'b1;
    r.want = {ev, cv, ch, cnt, ack, 4'd0, 1'b1};
    return r;
  endfunction

  // random word, mostly well-formed traffic against the channels in flight
  function automatic stim_row_t rand_row();
    stim_row_t r;
    int roll;
    int sel;
    int busy_list[$];
    roll = $urandom_range(0, 99);
    r = mk(KIND_POLL, ($urandom_range(0, 9) != 0), 2'($urandom_range(0, 3)),
           16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
           4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    if (roll < 30) begin
      r.w.kind = KIND_POLL;
    end else if (roll < 65) begin
      r.w.kind = KIND_RESP;
      for (int i = 0; i < NCH; i++) if (chan_active[i]) busy_list.push_back(i);
      if (busy_list.size() != 0 && $urandom_range(0, 4) != 0) begin
        sel = busy_list[$urandom_range(0, busy_list.size() - 1)];
        r.w.chv = 1'b1;
        r.w.chn = 2'(sel);
        roll = $urandom_range(0, 99);
        if (roll < 60) r.w.rep = 8'($urandom_range(0, chan_remainder[sel]));
        else if (roll < 85) r.w.rep = chan_remainder[sel];
      end
    end else if (roll < 85) begin
      r.w.kind = KIND_DISP;
      roll = $urandom_range(0, 99);
      if (roll < 70) r.w.amount = 16'($urandom_range(1, 40));
      else if (roll < 80) r.w.amount = '0;
      else if (roll < 90) r.w.amount = 16'hFFFF;
    end else if (roll < 90) begin
      r.w.kind = KIND_ATTACH;
    end else if (roll < 94) begin
      r.w.kind = KIND_PERR;
    end else begin
      r.w.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    end
    return r;
  endfunction

  // sender side
  int burst_left = 0;

  task automatic send_row(stim_row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    row_q.push_back(r);
    in_valid <= 1'b1;
    {in_kind, in_channel_valid, in_channel_number, in_ticket_amount,
     in_credit_accepted, in_credit_code, in_reported_tickets} <= r.w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every expected word is out, then let the core settle
  task automatic drain_link();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_timeout(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : link_driver
    stim_row_t directed[$];
    stim_row_t r;
    logic [7:0] settings[4];
    int n;
    int pause_at;

    for (int i = 0; i < NCH; i++) begin
      chan_pending[i] = '0;
      chan_active[i] = 1'b0;
      chan_remainder[i] = '0;
      chan_stall[i] = '0;
    end
    watchdog = '0;
    ack_toggle = 1'b0;
    listener_on = 1'b0;
    timeout_reg = TIMEOUT_RST;

    // directed table
    directed.push_back(mk_want(mk(KIND_POLL, 0, 0, 0, 0, 0, 0), EV_POLL, 0, 0, 0, 0));
    directed.push_back(mk_want(mk(KIND_DISP, 1, 3, 0, 0, 0, 0), EV_DONE, 1, 3, 0, 0));
    directed.push_back(mk_want(mk(KIND_DISP, 0, 2, 0, 1, 4'hF, 8'hFF), EV_DONE, 0, 2, 0, 0));
    directed.push_back(mk_want(mk(KIND_DISP, 0, 1, 16'hFFFF, 0, 0, 0),
                               EV_BAD_CH, 0, 0, 16'hFFFF, 0));
    directed.push_back(mk(KIND_SPARE_HI, 1, 3, 16'hFFFF, 1, 4'hF, 8'hFF));
    directed.push_back(mk(KIND_RESP, 1, 0, 0, 1, 4'hF, 8'hFF));
    directed.push_back(mk(KIND_ATTACH, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_want(mk(KIND_ATTACH, 0, 0, 0, 0, 0, 0), EV_REPLACED, 0, 0, 0, 0));
    directed.push_back(mk(KIND_DISP, 1, 0, 16'hFFFF, 0, 0, 0));
    directed.push_back(mk(KIND_DISP, 1, 1, 16'd20, 0, 0, 0));
    directed.push_back(mk(KIND_POLL, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_want(mk(KIND_DISP, 1, 0, 16'd5, 0, 0, 0), EV_BUSY, 1, 0, 5, 0));
    directed.push_back(mk(KIND_RESP, 1, 0, 0, 1, 4'd9, 8'd10));
    // remainder hits zero with tickets still owed: channel pauses
    directed.push_back(mk(KIND_RESP, 1, 0, 0, 0, 0, 8'd0));
    directed.push_back(mk(KIND_POLL, 0, 0, 0, 0, 0, 0));
    // no progress four times in a row: cancel on next poll
    repeat (4) directed.push_back(mk(KIND_RESP, 1, 0, 0, 0, 0, 8'd15));
    directed.push_back(mk(KIND_POLL, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(KIND_POLL, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(KIND_PERR, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(KIND_DISP, 1, 2, 16'd3, 0, 0, 0));
    directed.push_back(mk(KIND_POLL, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(KIND_RESP, 1, 2, 0, 0, 0, 8'd0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_row(directed[i]);
    drain_link();

    // random phases, each under its own response timeout
    settings[0] = 8'd0;
    settings[1] = 8'd255;
    settings[2] = 8'($urandom_range(1, 20));
    settings[3] = 8'd3;
    for (int p = 0; p < 4; p++) begin
      write_timeout(settings[p]);
      n = 0;
      pause_at = $urandom_range(10, PHASE_WORDS - 10);
      while (n < PHASE_WORDS) begin
        r = rand_row();
        send_row(r);
        if (r.w.kind <= KIND_PERR) n++;
        if (n == pause_at) begin
          drain_link();
          pause_at = -1;
        end
      end
      drain_link();
    end

    if (due_events.size() != 0) begin
      $error("%0d expected result words never arrived", due_events.size());
      fails++;
    end
    $display("covered %0d words, %0d result words, event codes seen mask %h",
             words_taken, results_seen, events_hit);
    $display("timeouts used: reset value, %0d, %0d, %0d, %0d",
             settings[0], settings[1], settings[2], settings[3]);
    if (fails == 0) begin
      $display("ticket_dispense_poll_controller_core test passed");
    end else begin
      $display("ticket_dispense_poll_controller_core test failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("ticket_dispense_poll_controller_core test failed");
    $finish;
  end

endmodule

### ticket_dispense_poll_controller_core.f
src/tdpc_pkg.sv
src/tdpc_ctrl.sv
src/tdpc_datapath.sv
src/ticket_dispense_poll_controller_core.sv
sim/tb.sv
